[hw/rtl/slmt_pkg.sv]
// Shared types, codes, constants and fixed-point helpers of the sigmoid layer trainer.
`timescale 1ns / 1ps
`default_nettype none
package slmt_pkg;

   localparam int IDX_W      = 6;
   localparam int KIND_W     = 3;
   localparam int DATA_W     = 16;
   localparam int SUM_W      = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int COEF_W     = 13;
   localparam int SIG_W      = 13;
   localparam int STEP_W     = 3;
   localparam int Q_FRAC     = 12;

   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 26;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int WIDE_W  = PROD_W - Q_FRAC;
   localparam int DER_W   = 20;
   localparam int G_W     = 32;
   localparam int GRAD_W  = 33;

   localparam int NUM_IN_DEF  = 64;
   localparam int NUM_OUT_DEF = 64;

   localparam logic [KIND_W-1:0] KIND_FORWARD  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ACTIVATE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_BACKPROP = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_LOAD     = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_ACT_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARN_RATE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MOMENTUM   = 2'd2;

   localparam logic [COEF_W-1:0] LEARN_RATE_RST = 13'd41;
   localparam logic [COEF_W-1:0] MOMENTUM_RST   = 13'd3686;

   localparam int RND_HALF = 2048;

   localparam logic signed [DATA_W:0] ONE_Q12_S = 17'sd4096;

   localparam logic [SUM_W-1:0] SIG_ONE     = 24'd4096;
   localparam logic [SUM_W-1:0] SIG_THR_SAT = 24'd20480;
   localparam logic [SUM_W-1:0] SIG_THR_HI  = 24'd9728;
   localparam logic [SUM_W-1:0] SIG_THR_MID = 24'd4096;
   localparam logic [SUM_W-1:0] SIG_OFS_HI  = 24'd3456;
   localparam logic [SUM_W-1:0] SIG_OFS_MID = 24'd2560;
   localparam logic [SUM_W-1:0] SIG_OFS_LO  = 24'd2048;

   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [WIDE_W-1:0] wide_type;

   localparam wide_type SUM_HI  = wide_type'(2 ** (SUM_W - 1) - 1);
   localparam wide_type SUM_LO  = wide_type'(-(2 ** (SUM_W - 1)));
   localparam wide_type DATA_HI = wide_type'(2 ** (DATA_W - 1) - 1);
   localparam wide_type DATA_LO = wide_type'(-(2 ** (DATA_W - 1)));

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_EXEC,
      ST_WRITE,
      ST_DONE
   } state_type;

   // round half up, then drop the twelve fraction bits
   function automatic wide_type rnd_q12(prod_type v);
      prod_type t;
      t = v + prod_type'(RND_HALF);
      return t[PROD_W-1:Q_FRAC];
   endfunction

   function automatic logic signed [SUM_W-1:0] sat_sum(wide_type v);
      logic signed [SUM_W-1:0] r;
      if (v > SUM_HI) begin
         r = SUM_HI[SUM_W-1:0];
      end else if (v < SUM_LO) begin
         r = SUM_LO[SUM_W-1:0];
      end else begin
         r = v[SUM_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_data(wide_type v);
      logic signed [DATA_W-1:0] r;
      if (v > DATA_HI) begin
         r = DATA_HI[DATA_W-1:0];
      end else if (v < DATA_LO) begin
         r = DATA_LO[DATA_W-1:0];
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   // piecewise-linear sigmoid with a Q1.12 result, odd-symmetric around one half
   function automatic logic [SIG_W-1:0] sigmoid_q12(logic signed [SUM_W-1:0] x);
      logic [SUM_W-1:0] a;
      logic [SUM_W-1:0] y;
      a = x[SUM_W-1] ? SUM_W'(-x) : x;
      if (a >= SIG_THR_SAT) begin
         y = SIG_ONE;
      end else if (a >= SIG_THR_HI) begin
         y = (a >> 5) + SIG_OFS_HI;
      end else if (a >= SIG_THR_MID) begin
         y = (a >> 3) + SIG_OFS_MID;
      end else begin
         y = (a >> 2) + SIG_OFS_LO;
      end
      if (x[SUM_W-1]) begin
         y = SIG_ONE - y;
      end
      return y[SIG_W-1:0];
   endfunction

endpackage
`default_nettype wire

[hw/rtl/slmt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module slmt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

[hw/rtl/sigmoid_layer_momentum_trainer_top.sv]
// Top level of the dense sigmoid layer engine with momentum SGD training.
//
// After reset the block sweeps its velocity, bias, neuron sum and back-error memories to zero,
// one address a cycle over all NUM_OUT*NUM_IN addresses; req_ready stays low
// meanwhile, while CSR writes are taken as usual. Each request then runs alone through one
// shared 33x26 signed multiplier under a step sequencer: a backprop update runs eight
// sequencer steps, six of them multiplies chained through the registered product, and the
// other kinds run fewer steps. The result sits in an output register, so the next request
// is accepted while it waits. Out-of-range neuron indices wrap modulo NUM_OUT and NUM_IN;
// a weight never loaded reads back as an arbitrary value.
`timescale 1ns / 1ps
`default_nettype none
module sigmoid_layer_momentum_trainer_top #(
   parameter int NUM_IN  = slmt_pkg::NUM_IN_DEF,
   parameter int NUM_OUT = slmt_pkg::NUM_OUT_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic        [slmt_pkg::KIND_W-1:0]  req_kind,
   input  wire logic        [slmt_pkg::IDX_W-1:0]   req_out_index,
   input  wire logic        [slmt_pkg::IDX_W-1:0]   req_in_index,
   input  wire logic signed [slmt_pkg::DATA_W-1:0]  req_in_value,
   input  wire logic signed [slmt_pkg::DATA_W-1:0]  req_target,
   input  wire logic signed [slmt_pkg::DATA_W-1:0]  req_weight_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed      [slmt_pkg::DATA_W-1:0]  rsp_neuron_value,
   output logic signed      [slmt_pkg::DATA_W-1:0]  rsp_weight_now,
   output logic signed      [slmt_pkg::DATA_W-1:0]  rsp_back_error,
   input  wire logic                                csr_wr_en,
   input  wire logic        [slmt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic        [slmt_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import slmt_pkg::*;

   localparam int OW     = (NUM_OUT > 1) ? $clog2(NUM_OUT) : 1;
   localparam int IW     = (NUM_IN > 1) ? $clog2(NUM_IN) : 1;
   localparam int WDEPTH = NUM_OUT * NUM_IN;
   localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
   localparam int IDX_N  = 2 ** IDX_W;

   // backprop step sequence
   localparam logic [STEP_W-1:0] BP_DER   = 3'd0;
   localparam logic [STEP_W-1:0] BP_G     = 3'd1;
   localparam logic [STEP_W-1:0] BP_WG    = 3'd2;
   localparam logic [STEP_W-1:0] BP_BERR  = 3'd3;
   localparam logic [STEP_W-1:0] BP_GRAD  = 3'd4;
   localparam logic [STEP_W-1:0] BP_ACC   = 3'd5;
   localparam logic [STEP_W-1:0] BP_VEL   = 3'd6;
   localparam logic [STEP_W-1:0] BP_LAST  = 3'd7;
   localparam logic [STEP_W-1:0] FWD_MUL  = 3'd0;
   localparam logic [STEP_W-1:0] FWD_LAST = 3'd1;
   localparam logic [STEP_W-1:0] ONE_LAST = 3'd0;

   // index wrap tables, constant per configuration
   logic [OW-1:0] omod_tab [IDX_N];
   logic [IW-1:0] imod_tab [IDX_N];
   for (genvar v = 0; v < IDX_N; v++) begin : g_mod
      assign omod_tab[v] = OW'(v % NUM_OUT);
      assign imod_tab[v] = IW'(v % NUM_IN);
   end

   state_type                 state_ff, state_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [WAW-1:0]            clr_ff, clr_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      mode_ff, mode_in;
   logic [COEF_W-1:0]         lr_ff, lr_in;
   logic [COEF_W-1:0]         mom_ff, mom_in;

   logic [KIND_W-1:0]         kind_ff, kind_in;
   logic [OW-1:0]             o_ff, o_in;
   logic [IW-1:0]             i_ff, i_in;
   logic [WAW-1:0]            wa_ff, wa_in;
   logic signed [DATA_W-1:0]  x_ff, x_in;
   logic signed [DATA_W-1:0]  tgt_ff, tgt_in;
   logic signed [DATA_W-1:0]  wval_ff, wval_in;
   logic signed [DATA_W-1:0]  w_ff, w_in;
   logic signed [DATA_W-1:0]  vel_ff, vel_in;
   logic signed [DATA_W-1:0]  bias_ff, bias_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [SUM_W-1:0]   berr_ff, berr_in;
   prod_type                  prod_ff, prod_in;
   prod_type                  acc_ff, acc_in;
   logic signed [G_W-1:0]     t_ff, t_in;
   logic signed [GRAD_W-1:0]  grad_ff, grad_in;
   logic signed [DATA_W-1:0]  rsp_nv_ff, rsp_nv_in;
   logic signed [DATA_W-1:0]  rsp_wn_ff, rsp_wn_in;
   logic signed [DATA_W-1:0]  rsp_be_ff, rsp_be_in;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [DATA_W:0]    one_minus_x;
   wide_type                  prod_rnd;
   logic signed [DER_W-1:0]   der;
   logic [STEP_W-1:0]         last_step;

   logic                      clearing;
   logic                      mem_we;
   logic                      out_clr_ok;
   logic                      in_clr_ok;
   logic [DATA_W-1:0]         w_rd, vel_rd, bias_rd;
   logic [SUM_W-1:0]          sum_rd, berr_rd;

   assign one_minus_x = ONE_Q12_S - (DATA_W + 1)'(x_ff);
   assign prod_rnd    = rnd_q12(prod_ff);
   assign der         = prod_rnd[DER_W-1:0];

   always_comb begin
      unique case (kind_ff)
         KIND_BACKPROP: last_step = BP_LAST;
         KIND_FORWARD:  last_step = FWD_LAST;
         default:       last_step = ONE_LAST;
      endcase
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (kind_ff == KIND_BACKPROP) begin
         unique case (step_ff)
            BP_DER: begin
               mul_a = MUL_A_W'(one_minus_x);
               mul_b = MUL_B_W'(x_ff);
            end
            BP_G: begin
               mul_a = MUL_A_W'(der);
               mul_b = $signed(t_ff[MUL_B_W-1:0]);
            end
            BP_WG: begin
               mul_a = MUL_A_W'($signed(prod_rnd[G_W-1:0]));
               mul_b = MUL_B_W'(w_ff);
            end
            BP_BERR: begin
               mul_a = MUL_A_W'(t_ff);
               mul_b = MUL_B_W'({1'b0, lr_ff});
            end
            BP_GRAD: begin
               mul_a = MUL_A_W'(vel_ff);
               mul_b = MUL_B_W'({1'b0, mom_ff});
            end
            BP_ACC: begin
               mul_a = MUL_A_W'(grad_ff);
               mul_b = MUL_B_W'(x_ff);
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end else begin
         mul_a = MUL_A_W'(w_ff);
         mul_b = MUL_B_W'(x_ff);
      end
   end

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff;
      mode_in      = mode_ff;
      lr_in        = lr_ff;
      mom_in       = mom_ff;
      kind_in      = kind_ff;
      o_in         = o_ff;
      i_in         = i_ff;
      wa_in        = wa_ff;
      x_in         = x_ff;
      tgt_in       = tgt_ff;
      wval_in      = wval_ff;
      w_in         = w_ff;
      vel_in       = vel_ff;
      bias_in      = bias_ff;
      sum_in       = sum_ff;
      berr_in      = berr_ff;
      acc_in       = acc_ff;
      t_in         = t_ff;
      grad_in      = grad_ff;
      rsp_nv_in    = rsp_nv_ff;
      rsp_wn_in    = rsp_wn_ff;
      rsp_be_in    = rsp_be_ff;
      prod_in      = mul_a * mul_b;
      req_ready    = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ACT_MODE:   mode_in = csr_wr_data[0];
            CSR_LEARN_RATE: lr_in   = csr_wr_data[COEF_W-1:0];
            CSR_MOMENTUM:   mom_in  = csr_wr_data[COEF_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + WAW'(1);
            if (clr_ff == WAW'(WDEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in  = req_kind;
               o_in     = omod_tab[req_out_index];
               i_in     = imod_tab[req_in_index];
               wa_in    = WAW'(omod_tab[req_out_index]) * WAW'(NUM_IN)
                        + WAW'(imod_tab[req_in_index]);
               x_in     = req_in_value;
               tgt_in   = req_target;
               wval_in  = req_weight_value;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            w_in     = $signed(w_rd);
            vel_in   = $signed(vel_rd);
            bias_in  = $signed(bias_rd);
            sum_in   = $signed(sum_rd);
            berr_in  = $signed(berr_rd);
            step_in  = '0;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            unique case (kind_ff)
               KIND_FORWARD: begin
                  if (step_ff == FWD_LAST) begin
                     sum_in = sat_sum(wide_type'(sum_ff) + prod_rnd);
                  end
               end
               KIND_ACTIVATE: begin
                  if (!mode_ff) begin
                     sum_in = $signed(SUM_W'(sigmoid_q12(
                        sat_sum(wide_type'(sum_ff) + wide_type'(bias_ff)))));
                  end
               end
               KIND_BACKPROP: begin
                  unique case (step_ff)
                     BP_DER:  t_in    = G_W'((wide_type'(sum_ff) - wide_type'(tgt_ff)) <<< 1);
                     BP_WG:   t_in    = prod_rnd[G_W-1:0];
                     BP_BERR: berr_in = sat_sum(wide_type'(berr_ff) + prod_rnd);
                     BP_GRAD: grad_in = prod_rnd[GRAD_W-1:0];
                     BP_ACC:  acc_in  = prod_ff;
                     BP_VEL:  vel_in  = sat_data(rnd_q12(acc_ff - prod_ff));
                     BP_LAST: begin
                        w_in    = sat_data(wide_type'(w_ff) + wide_type'(vel_ff));
                        bias_in = sat_data(wide_type'(bias_ff) - wide_type'(grad_ff));
                     end
                     default: ;
                  endcase
               end
               KIND_CLEAR: begin
                  sum_in  = '0;
                  berr_in = '0;
               end
               KIND_LOAD: begin
                  w_in = wval_ff;
               end
               default: ;
            endcase
            if (step_ff == last_step) begin
               state_in = ST_WRITE;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_WRITE: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_nv_in    = sat_data(wide_type'(sum_ff));
               rsp_wn_in    = w_ff;
               rsp_be_in    = sat_data(wide_type'(berr_ff));
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= 1'b0;
         lr_ff        <= LEARN_RATE_RST;
         mom_ff       <= MOMENTUM_RST;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         lr_ff        <= lr_in;
         mom_ff       <= mom_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      o_ff      <= o_in;
      i_ff      <= i_in;
      wa_ff     <= wa_in;
      x_ff      <= x_in;
      tgt_ff    <= tgt_in;
      wval_ff   <= wval_in;
      w_ff      <= w_in;
      vel_ff    <= vel_in;
      bias_ff   <= bias_in;
      sum_ff    <= sum_in;
      berr_ff   <= berr_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      t_ff      <= t_in;
      grad_ff   <= grad_in;
      rsp_nv_ff <= rsp_nv_in;
      rsp_wn_ff <= rsp_wn_in;
      rsp_be_ff <= rsp_be_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_neuron_value = rsp_nv_ff;
   assign rsp_weight_now   = rsp_wn_ff;
   assign rsp_back_error   = rsp_be_ff;

   // memories: all but the weight RAM cleared by the sweep, all written back once per request
   assign clearing   = (state_ff == ST_CLEAR);
   assign mem_we     = clearing || (state_ff == ST_WRITE);
   assign out_clr_ok = ({1'b0, clr_ff} < (WAW + 1)'(NUM_OUT));
   assign in_clr_ok  = ({1'b0, clr_ff} < (WAW + 1)'(NUM_IN));

   slmt_ram #(.WIDTH(DATA_W), .DEPTH(WDEPTH)) u_weight_ram (
      .clock   (clock),
      .wr_en   (state_ff == ST_WRITE),
      .wr_addr (wa_ff),
      .wr_data (w_ff),
      .rd_addr (wa_ff),
      .rd_data (w_rd)
   );

   slmt_ram #(.WIDTH(DATA_W), .DEPTH(WDEPTH)) u_velocity_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (clearing ? clr_ff : wa_ff),
      .wr_data (clearing ? '0 : vel_ff),
      .rd_addr (wa_ff),
      .rd_data (vel_rd)
   );

   slmt_ram #(.WIDTH(DATA_W), .DEPTH(NUM_OUT)) u_bias_ram (
      .clock   (clock),
      .wr_en   (clearing ? out_clr_ok : mem_we),
      .wr_addr (clearing ? clr_ff[OW-1:0] : o_ff),
      .wr_data (clearing ? '0 : bias_ff),
      .rd_addr (o_ff),
      .rd_data (bias_rd)
   );

   slmt_ram #(.WIDTH(SUM_W), .DEPTH(NUM_OUT)) u_sum_ram (
      .clock   (clock),
      .wr_en   (clearing ? out_clr_ok : mem_we),
      .wr_addr (clearing ? clr_ff[OW-1:0] : o_ff),
      .wr_data (clearing ? '0 : sum_ff),
      .rd_addr (o_ff),
      .rd_data (sum_rd)
   );

   slmt_ram #(.WIDTH(SUM_W), .DEPTH(NUM_IN)) u_berr_ram (
      .clock   (clock),
      .wr_en   (clearing ? in_clr_ok : mem_we),
      .wr_addr (clearing ? clr_ff[IW-1:0] : i_ff),
      .wr_data (clearing ? '0 : berr_ff),
      .rd_addr (i_ff),
      .rd_data (berr_rd)
   );

   a_reset_sweep : assert property (@(posedge clock)
      $fell(reset) |-> state_ff == ST_CLEAR)
      else $error("clearing sweep not started after reset");

   a_accept_read : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_READ)
      else $error("accepted request did not start a memory read");

   a_step_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && kind_ff != KIND_BACKPROP) |-> step_ff <= FWD_LAST)
      else $error("step counter ran past the last step of a short kind");

   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside the done state");

endmodule
`default_nettype wire
